FILE: design/kat_pkg.sv
package kat_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W       = 32;

    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 3;
    localparam int TOTAL_W     = 4;
    localparam int RESULT_W    = STATUS_W + INDEX_W + TOTAL_W;
    localparam int M_DATA_W    = ((RESULT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_CANCEL = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } state_t;

endpackage

FILE: design/keyed_alert_table.sv
// Alert source table of kat_pkg::TABLE_SLOTS slots keyed by a 32-bit source address.
// One item is handled at a time: after acceptance a single 32-bit comparator walks the
// filled slots from slot 0, one slot per cycle, stopping at the first match or after the
// last filled slot; S_UPDATE then applies the update and loads the result register.
// The key of each slot is read from the slot store into a register the cycle before its
// compare. The result is offered in S_RESP after S_UPDATE, and the next item is taken in
// the cycle after the result is accepted. No clearing pass is needed after reset.
// s_tready is low from acceptance until the result has been taken.
module keyed_alert_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [kat_pkg::KEY_W-1:0]    s_tdata,   // source_address[31:0]
    input  logic                         s_tuser,   // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], slot_index[4:2], active_total[8:5], zero pad above
    output logic [kat_pkg::M_DATA_W-1:0] m_tdata
);

    kat_pkg::state_t                 state_reg, state_next;
    logic [kat_pkg::KEY_W-1:0]       key_reg, key_next;
    kat_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [kat_pkg::CNT_W-1:0]       scan_reg, scan_next;
    logic                            hit_reg, hit_next;
    logic [kat_pkg::CNT_W-1:0]       used_reg, used_next;
    logic [kat_pkg::TABLE_SLOTS-1:0] active_reg, active_next;
    logic [kat_pkg::CNT_W-1:0]       act_cnt_reg, act_cnt_next;
    logic [kat_pkg::M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [kat_pkg::KEY_W-1:0]       slot_key_mem [kat_pkg::TABLE_SLOTS];
    logic [kat_pkg::KEY_W-1:0]       rd_key_reg;
    logic                            mem_we;
    logic [kat_pkg::SLOT_W-1:0]      mem_waddr;

    logic [kat_pkg::SLOT_W-1:0]      cur_idx;
    logic                            scan_end;
    logic                            key_match;
    kat_pkg::status_t                status;
    logic [kat_pkg::INDEX_W-1:0]     res_idx;

    assign cur_idx   = scan_reg[kat_pkg::SLOT_W-1:0];
    assign scan_end  = (scan_reg == used_reg);
    // rd_key_reg holds the key of slot scan_reg
    assign key_match = (rd_key_reg == key_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kat_pkg::S_IDLE: begin
                if (s_tvalid) state_next = kat_pkg::S_SCAN;
            end
            kat_pkg::S_SCAN: begin
                if (scan_end || key_match) state_next = kat_pkg::S_UPDATE;
            end
            kat_pkg::S_UPDATE: state_next = kat_pkg::S_RESP;
            kat_pkg::S_RESP: begin
                if (m_tready) state_next = kat_pkg::S_IDLE;
            end
            default: state_next = kat_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        key_next     = key_reg;
        cmd_next     = cmd_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        used_next    = used_reg;
        active_next  = active_reg;
        act_cnt_next = act_cnt_reg;
        m_tdata_next = m_tdata_reg;
        mem_we       = 1'b0;
        mem_waddr    = used_reg[kat_pkg::SLOT_W-1:0];
        status       = kat_pkg::ST_DONE;
        res_idx      = '0;
        case (state_reg)
            kat_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                key_next  = s_tdata;
                cmd_next  = kat_pkg::cmd_t'(s_tuser);
                scan_next = '0;
                hit_next  = 1'b0;
            end
            kat_pkg::S_SCAN: begin
                if (scan_end) begin
                    hit_next = 1'b0;
                end else if (key_match) begin
                    hit_next = 1'b1;
                end else begin
                    scan_next = scan_reg + kat_pkg::CNT_W'(1);
                end
            end
            kat_pkg::S_UPDATE: begin
                // on a miss scan_reg equals used_reg, the append slot
                if (hit_reg) begin
                    if (cmd_reg == kat_pkg::CMD_RECORD) begin
                        if (!active_reg[cur_idx]) act_cnt_next = act_cnt_reg + kat_pkg::CNT_W'(1);
                        active_next[cur_idx] = 1'b1;
                    end else begin
                        if (active_reg[cur_idx]) act_cnt_next = act_cnt_reg - kat_pkg::CNT_W'(1);
                        active_next[cur_idx] = 1'b0;
                    end
                end else if (cmd_reg == kat_pkg::CMD_CANCEL) begin
                    status = kat_pkg::ST_NOT_FOUND;
                end else if (used_reg == kat_pkg::CNT_W'(kat_pkg::TABLE_SLOTS)) begin
                    status = kat_pkg::ST_FULL;
                end else begin
                    mem_we               = 1'b1;
                    active_next[cur_idx] = 1'b1;
                    act_cnt_next         = act_cnt_reg + kat_pkg::CNT_W'(1);
                    used_next            = used_reg + kat_pkg::CNT_W'(1);
                end
                if (status == kat_pkg::ST_DONE) res_idx = kat_pkg::INDEX_W'(cur_idx);
                m_tdata_next = kat_pkg::M_DATA_W'({kat_pkg::TOTAL_W'(act_cnt_next),
                                                   res_idx, status});
            end
            kat_pkg::S_RESP: begin
                m_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kat_pkg::S_IDLE;
            used_reg    <= '0;
            active_reg  <= '0;
            act_cnt_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            active_reg  <= active_next;
            act_cnt_reg <= act_cnt_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        cmd_reg     <= cmd_next;
        scan_reg    <= scan_next;
        m_tdata_reg <= m_tdata_next;
    end

    // key of the slot compared in the next cycle
    always_ff @(posedge aclk) begin
        if (mem_we) slot_key_mem[mem_waddr] <= key_reg;
        rd_key_reg <= slot_key_mem[scan_next[kat_pkg::SLOT_W-1:0]];
    end

    assign m_tdata = m_tdata_reg;

    a_used_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= kat_pkg::CNT_W'(kat_pkg::TABLE_SLOTS))
        else $error("fill count beyond table size");

    a_active_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        act_cnt_reg <= used_reg)
        else $error("active count exceeds filled slots");

    a_active_filled : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(active_reg) == int'(act_cnt_reg))
        else $error("active count out of step with active marks");

    a_one_item : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("new item taken while one is in flight");

    a_scan_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kat_pkg::S_SCAN) |-> (scan_reg <= used_reg))
        else $error("search ran past filled slots");

endmodule

FILE: bench/keyed_alert_table_chk.sv
module keyed_alert_table_chk
    import kat_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [KEY_W-1:0]    s_tdata,   // source_address[31:0]
    input  logic                s_tuser,   // command
    input  logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], slot_index[4:2], active_total[8:5], zero pad above
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] slot;
        logic [TOTAL_W-1:0] active;
    } alert_result_t;

    // shadow copy of the table
    logic [KEY_W-1:0] source_keys [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] source_live;
    int slots_filled;

    alert_result_t alert_results_due [$];

    // updates the shadow table and returns the reply for one item
    function automatic alert_result_t apply_alert_item(cmd_t cmd, logic [KEY_W-1:0] addr);
        alert_result_t r;
        int hit;
        int live;
        int i;
        hit = -1;
        live = 0;
        r.status = ST_DONE;
        r.slot = '0;
        for (i = 0; i < slots_filled; i++) begin
            if (hit < 0 && source_keys[i] == addr)
                hit = i;
        end
        if (cmd == CMD_RECORD) begin
            if (hit >= 0) begin
                source_live[hit] = 1'b1;
                r.slot = INDEX_W'(hit);
            end else if (slots_filled >= TABLE_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                source_keys[slots_filled] = addr;
                source_live[slots_filled] = 1'b1;
                r.slot = INDEX_W'(slots_filled);
                slots_filled++;
            end
        end else begin
            if (hit >= 0) begin
                source_live[hit] = 1'b0;
                r.slot = INDEX_W'(hit);
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        for (i = 0; i < slots_filled; i++)
            live += source_live[i];
        r.active = TOTAL_W'(live);
        return r;
    endfunction

    always @(posedge aclk) begin
        alert_result_t seen;
        alert_result_t want;
        logic [M_DATA_W-RESULT_W-1:0] pad;
        string seen_txt;
        string want_txt;
        if (!aresetn) begin
            slots_filled = 0;
            source_live = '0;
            alert_results_due.delete();
            pending = 0;
            mismatches = 0;
        end else begin
            // results belong to earlier items, so retire before predicting
            if (m_tvalid && m_tready) begin
                seen.status = status_t'(m_tdata[STATUS_W-1:0]);
                seen.slot = m_tdata[STATUS_W +: INDEX_W];
                seen.active = m_tdata[STATUS_W+INDEX_W +: TOTAL_W];
                pad = m_tdata[M_DATA_W-1:RESULT_W];
                seen_txt = $sformatf("status=%0d slot=%0d active=%0d pad=%0h",
                                     seen.status, seen.slot, seen.active, pad);
                if (alert_results_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %s",
                             $time, seen_txt);
                    mismatches++;
                end else begin
                    want = alert_results_due.pop_front();
                    if (seen !== want || pad !== '0) begin
                        want_txt = $sformatf("status=%0d slot=%0d active=%0d pad=0",
                                             want.status, want.slot, want.active);
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, want_txt, seen_txt);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                alert_results_due.push_back(apply_alert_item(cmd_t'(s_tuser), s_tdata));
            pending = alert_results_due.size();
        end
    end

endmodule

FILE: bench/keyed_alert_table_tb.sv
module keyed_alert_table_tb;

    import kat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int QUIET_ITEMS    = 200;
    localparam int SETTLE_CYCLES  = 2 * (TABLE_SLOTS + 3);
    localparam int WATCHDOG_LIMIT = 2000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [KEY_W-1:0]    s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int  mismatches;
    int  pending;
    int  idle_cycles = 0;
    bit  quiet_tail = 1'b0;

    logic [KEY_W-1:0] table_keys [TABLE_SLOTS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    keyed_alert_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    keyed_alert_table_chk u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // hands one item over, with an occasional gap in front of it
    task automatic send_alert(cmd_t cmd, logic [KEY_W-1:0] addr);
        @(negedge aclk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side backpressure
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int   n;
        int   pick;
        cmd_t cmd;
        logic [KEY_W-1:0] addr;

        table_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001, 32'h1234_5678};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, repeats, near miss, fill up, then overflow
        send_alert(CMD_CANCEL, table_keys[0]);
        send_alert(CMD_RECORD, table_keys[0]);
        send_alert(CMD_RECORD, table_keys[1]);
        send_alert(CMD_RECORD, table_keys[0]);
        send_alert(CMD_CANCEL, table_keys[0]);
        send_alert(CMD_CANCEL, table_keys[0]);
        send_alert(CMD_RECORD, table_keys[0]);
        send_alert(CMD_CANCEL, 32'hFFFF_FFFE);
        for (n = 2; n < TABLE_SLOTS; n++)
            send_alert(CMD_RECORD, table_keys[n]);
        send_alert(CMD_RECORD, 32'h0000_0002);
        send_alert(CMD_RECORD, table_keys[TABLE_SLOTS-1]);
        send_alert(CMD_CANCEL, table_keys[TABLE_SLOTS-1]);
        send_alert(CMD_CANCEL, 32'h0000_0002);
        send_alert(CMD_RECORD, table_keys[1]);
        send_alert(CMD_CANCEL, table_keys[2]);

        // mostly known sources, some one-bit near misses and unknown sources
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            cmd = cmd_t'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                addr = table_keys[$urandom_range(0, TABLE_SLOTS - 1)];
            else if (pick == 7)
                addr = table_keys[$urandom_range(0, TABLE_SLOTS - 1)]
                       ^ (32'h1 << $urandom_range(0, KEY_W - 1));
            else
                addr = $urandom;
            send_alert(cmd, addr);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
design/kat_pkg.sv
design/keyed_alert_table.sv
bench/keyed_alert_table_chk.sv
bench/keyed_alert_table_tb.sv
